@@ hdl/dbio_pkg.sv @@
// types and constants shared by the debounced input / timed output pin bank
// no dependencies; used by dbio_alu, the top level and its testbench
package dbio_pkg;

	// command codes carried by the opcode field
	typedef enum logic [1:0] {
		OP_TICK        = 2'd0,
		OP_DRIVE_HIGH  = 2'd1,
		OP_DRIVE_LOW   = 2'd2,
		OP_READ_CLEAR  = 2'd3
	} opcode_t;

	// per-pin debounce phase, code 3 is never stored
	typedef enum logic [1:0] {
		PH_WAIT_CHANGE  = 2'd0,
		PH_WAIT_SETTLE  = 2'd1,
		PH_WAIT_RELEASE = 2'd2
	} phase_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_EXEC = 2'd2,
		ST_RESP = 2'd3
	} state_t;

	// shared arithmetic unit operations
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// shared unit result and compare flags
	typedef struct packed {
		logic [31:0] sum;
		logic        a_ge_b;
		logic        sum_ge_lim;
	} alu_res_t;

	// pin mode codes
	localparam logic [1:0] MODE_UNUSED = 2'd0;
	localparam logic [1:0] MODE_INPUT  = 2'd1;
	localparam logic [1:0] MODE_OUTPUT = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_MODES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS = 2'd1;

	localparam logic [15:0] SETTLE_RESET = 16'd50;

endpackage

@@ hdl/debounced_input_and_timed_output_pins.sv @@
// top level of the debounced input / timed output pin bank
// depends on dbio_pkg, dbio_alu and dbio_mark_mem
//
// A command is taken when start is high and busy is low; busy then stays high
// until the single result beat, marked by done for exactly one cycle, has gone
// out. The receiver cannot stall, so drive_levels, activated and
// activated_flags must be captured in the done cycle. A tick walks the pins one
// per cycle through the shared add/subtract unit and the mark time store, whose
// registered read runs one pin ahead of the evaluation; the next command can be
// accepted the cycle after done. Drive high, drive low and read-clear pass
// through the execute state before the result beat. The configuration port is
// always ready; writes are meant to happen while busy is low. Unknown register
// indexes are ignored.
module debounced_input_and_timed_output_pins #(
	parameter int unsigned PIN_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command beat
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [3:0]                         pin,
	input  logic [31:0]                        duration_ms,
	input  logic [31:0]                        now_ms,
	input  logic [15:0]                        pin_levels,
	// result beat
	output logic                               done,
	output logic [15:0]                        drive_levels,
	output logic                               activated,
	output logic [15:0]                        activated_flags,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dbio_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);

	localparam int unsigned PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(PIN_COUNT + 1);

	// sequencer
	dbio_pkg::state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_en;
	logic             accept;

	// scan pipeline: pin whose mark time read is in flight
	logic [PIN_W-1:0] idx_s1;
	logic             vld_s1;

	// latched command beat
	dbio_pkg::opcode_t op_q;
	logic [3:0]        pin_q;
	logic [31:0]       dur_q;
	logic [31:0]       now_q;
	logic [15:0]       lvl_q;
	logic              act_res_q;

	// configuration registers
	logic [31:0] modes_q;
	logic [15:0] settle_q;

	// per-pin state kept in flops
	dbio_pkg::phase_t [PIN_COUNT-1:0] phase_q;
	logic [PIN_COUNT-1:0]             act_q;
	logic [PIN_COUNT-1:0]             drv_q;

	// shared unit
	dbio_pkg::alu_op_t  alu_op;
	logic [31:0]        alu_b;
	dbio_pkg::alu_res_t alu_r;

	// mark store
	logic             mem_we;
	logic [PIN_W-1:0] mem_waddr;
	logic [31:0]      mem_wdata;
	logic [31:0]      rd_data;

	// evaluation of the pin in stage 1
	logic [31:0]       mode_sh;
	logic [15:0]       lvl_sh;
	logic [1:0]        ev_mode;
	logic              ev_low;
	dbio_pkg::phase_t  ev_phase;
	logic              ev_act;
	logic              ph_we;
	dbio_pkg::phase_t  ph_nx;
	logic              act_set;
	logic              mark_now;
	logic              out_exp;

	// command decode
	logic             in_rng;
	logic [PIN_W-1:0] pin_idx;
	logic             exec_drive;

	logic [31:0] drv_ext;
	logic [31:0] act_ext;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q  <= 32'd0;
			settle_q <= dbio_pkg::SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dbio_pkg::REG_PIN_MODES: modes_q  <= cfg_data;
				dbio_pkg::REG_SETTLE_MS: settle_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer: next state and strobes
	always_comb begin
		st_d  = st_q;
		rd_en = 1'b0;
		busy  = 1'b1;
		done  = 1'b0;
		case (st_q)
			dbio_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (dbio_pkg::opcode_t'(opcode) == dbio_pkg::OP_TICK) begin
						st_d = dbio_pkg::ST_SCAN;
					end else begin
						st_d = dbio_pkg::ST_EXEC;
					end
				end
			end
			dbio_pkg::ST_SCAN: begin
				// issue reads for pins 0..PIN_COUNT-1, then drain stage 1 before the result beat
				if (cnt_q < CNT_W'(PIN_COUNT)) begin
					rd_en = 1'b1;
				end else begin
					st_d = dbio_pkg::ST_RESP;
				end
			end
			dbio_pkg::ST_EXEC: begin
				st_d = dbio_pkg::ST_RESP;
			end
			dbio_pkg::ST_RESP: begin
				done = 1'b1;
				st_d = dbio_pkg::ST_IDLE;
			end
			default: begin
				st_d = dbio_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= dbio_pkg::ST_IDLE;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			st_q   <= st_d;
			vld_s1 <= rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[PIN_W-1:0];
		end
		if (accept) begin
			op_q  <= dbio_pkg::opcode_t'(opcode);
			pin_q <= pin;
			dur_q <= duration_ms;
			now_q <= now_ms;
			lvl_q <= pin_levels;
		end
	end

	// ------------------------------------------------------------------
	// shared unit: now + duration for a drive-high command,
	// now - mark time while scanning
	always_comb begin
		if (st_q == dbio_pkg::ST_EXEC) begin
			alu_op = dbio_pkg::ALU_ADD;
			alu_b  = dur_q;
		end else begin
			alu_op = dbio_pkg::ALU_SUB;
			alu_b  = rd_data;
		end
	end

	dbio_alu u_alu (
		.op  (alu_op),
		.a   (now_q),
		.b   (alu_b),
		.lim (settle_q),
		.res (alu_r)
	);

	// ------------------------------------------------------------------
	// per-pin evaluation during a tick
	// only pins 0..15 have mode bits and level bits; others are unused
	assign mode_sh  = modes_q >> {idx_s1, 1'b0};
	assign lvl_sh   = lvl_q >> idx_s1;
	assign ev_mode  = (32'(idx_s1) < 32'd16) ? mode_sh[1:0] : dbio_pkg::MODE_UNUSED;
	assign ev_low   = (32'(idx_s1) < 32'd16) && !lvl_sh[0];
	assign ev_phase = phase_q[idx_s1];
	assign ev_act   = act_q[idx_s1];

	always_comb begin
		ph_we    = 1'b0;
		ph_nx    = ev_phase;
		act_set  = 1'b0;
		mark_now = 1'b0;
		out_exp  = 1'b0;
		if (vld_s1) begin
			if (ev_mode == dbio_pkg::MODE_INPUT) begin
				case (ev_phase)
					dbio_pkg::PH_WAIT_SETTLE: begin
						if (!ev_low) begin
							ph_we = 1'b1;
							ph_nx = dbio_pkg::PH_WAIT_CHANGE;
						end else if (alu_r.sum_ge_lim) begin
							// wrap-safe elapsed time reached the settle time
							ph_we   = 1'b1;
							ph_nx   = dbio_pkg::PH_WAIT_RELEASE;
							act_set = 1'b1;
						end
					end
					dbio_pkg::PH_WAIT_RELEASE: begin
						// leave only once released and the flag has been read
						if (!ev_low && !ev_act) begin
							ph_we = 1'b1;
							ph_nx = dbio_pkg::PH_WAIT_CHANGE;
						end
					end
					default: begin
						// waiting for change, also the unreachable code 3
						if (ev_low) begin
							ph_we    = 1'b1;
							ph_nx    = dbio_pkg::PH_WAIT_SETTLE;
							mark_now = 1'b1;
						end
					end
				endcase
			end else if (ev_mode == dbio_pkg::MODE_OUTPUT) begin
				// a zero deadline never expires; otherwise plain unsigned compare
				if ((rd_data != 32'd0) && alu_r.a_ge_b) begin
					out_exp = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// single-pin commands
	assign in_rng     = 32'(pin_q) < PIN_COUNT;
	assign pin_idx    = PIN_W'(pin_q);
	assign exec_drive = (st_q == dbio_pkg::ST_EXEC) && in_rng &&
	                    ((op_q == dbio_pkg::OP_DRIVE_HIGH) || (op_q == dbio_pkg::OP_DRIVE_LOW));

	// mark store write port: commands in EXEC, scan updates in SCAN
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = 32'd0;
		if (exec_drive) begin
			mem_we    = 1'b1;
			mem_waddr = pin_idx;
			mem_wdata = (op_q == dbio_pkg::OP_DRIVE_HIGH) ? alu_r.sum : 32'd0;
		end else if (mark_now || out_exp) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1;
			mem_wdata = mark_now ? now_q : 32'd0;
		end
	end

	dbio_mark_mem #(
		.DEPTH (PIN_COUNT),
		.AW    (PIN_W)
	) u_mark_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (cnt_q[PIN_W-1:0]),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------
	// per-pin flop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			act_q     <= '0;
			drv_q     <= '0;
			act_res_q <= 1'b0;
		end else begin
			if (accept) begin
				act_res_q <= 1'b0;
			end
			if (ph_we) begin
				phase_q[idx_s1] <= ph_nx;
			end
			if (act_set) begin
				act_q[idx_s1] <= 1'b1;
			end
			if (out_exp) begin
				drv_q[idx_s1] <= 1'b0;
			end
			if ((st_q == dbio_pkg::ST_EXEC) && in_rng) begin
				case (op_q)
					dbio_pkg::OP_DRIVE_HIGH: drv_q[pin_idx] <= 1'b1;
					dbio_pkg::OP_DRIVE_LOW:  drv_q[pin_idx] <= 1'b0;
					dbio_pkg::OP_READ_CLEAR: begin
						act_res_q      <= act_q[pin_idx];
						act_q[pin_idx] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// result beat: only pins 0..15 are shown
	assign drv_ext         = 32'(drv_q);
	assign act_ext         = 32'(act_q);
	assign drive_levels    = drv_ext[15:0];
	assign activated_flags = act_ext[15:0];
	assign activated       = act_res_q;

	// ------------------------------------------------------------------
	// assertions
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command beat taken but busy did not rise");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result beat");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in progress");

	a_scan_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (st_q == dbio_pkg::ST_SCAN))
		else $error("pin evaluation outside a tick scan");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("mark store written while idle");

endmodule

@@ hdl/dbio_alu.sv @@
// shared 32-bit add/subtract unit with unsigned compare flags
// depends on dbio_pkg
module dbio_alu (
	input  dbio_pkg::alu_op_t  op,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [15:0]        lim,
	output dbio_pkg::alu_res_t res
);

	logic [32:0] wide;

	always_comb begin
		if (op == dbio_pkg::ALU_ADD) begin
			wide = {1'b0, a} + {1'b0, b};
		end else begin
			wide = {1'b0, a} - {1'b0, b};
		end
		res.sum        = wide[31:0];
		// no borrow on subtract means a >= b
		res.a_ge_b     = ~wide[32];
		res.sum_ge_lim = wide[31:0] >= {16'd0, lim};
	end

endmodule

@@ hdl/dbio_mark_mem.sv @@
// per-pin mark time store: one write port, one registered read port
// entries never written read as zero; depends on nothing
module dbio_mark_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : 32'd0;

endmodule

@@ tb/tb_debounced_input_and_timed_output_pins.sv @@
// self-checking testbench for the debounced input / timed output pin bank
// depends on dbio_pkg and debounced_input_and_timed_output_pins; an internal
// predictor works out every result beat and a checker compares the done beats
module tb_debounced_input_and_timed_output_pins;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIN_COUNT    = 16;
	localparam int unsigned STALL_LIMIT  = 1000;          // quiet cycles before giving up
	localparam int unsigned DRAIN_CYCLES = PIN_COUNT + 4; // longer than a tick from acceptance to done
	localparam int unsigned MAX_PRINTS   = 40;
	localparam int unsigned PHASE_ITEMS  = 75;

	// mode code 3 has no meaning in the block, pins with it are left alone by a tick
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	// register indexes that the block does not decode
	localparam logic [dbio_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [dbio_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// one result beat, field by field
	typedef struct packed {
		logic [15:0] drive_levels;
		logic        activated;
		logic [15:0] activated_flags;
	} pin_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [1:0]                     opcode;
	logic [3:0]                     pin;
	logic [31:0]                    duration_ms;
	logic [31:0]                    now_ms;
	logic [15:0]                    pin_levels;
	logic                           done;
	logic [15:0]                    drive_levels;
	logic                           activated;
	logic [15:0]                    activated_flags;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [dbio_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                    cfg_data;

	// predicted pin bank state
	logic [31:0]      mode_word;
	logic [15:0]      settle_word;
	dbio_pkg::phase_t deb_phase [PIN_COUNT];
	logic [31:0]      mark_ms   [PIN_COUNT];  // low-start time for inputs, deadline for outputs
	logic [15:0]      act_flags;
	logic [15:0]      drv_bits;

	// results still owed by the block, oldest first
	pin_result_t pending_results [$];

	int unsigned error_count;
	int unsigned burst_left;
	int unsigned n_ticks;
	int unsigned n_drive_high;
	int unsigned n_drive_low;
	int unsigned n_reads;
	int unsigned n_flags_read;
	int unsigned n_cfg_writes;
	int unsigned idle_cycles;

	debounced_input_and_timed_output_pins #(
		.PIN_COUNT(PIN_COUNT)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.pin             (pin),
		.duration_ms     (duration_ms),
		.now_ms          (now_ms),
		.pin_levels      (pin_levels),
		.done            (done),
		.drive_levels    (drive_levels),
		.activated       (activated),
		.activated_flags (activated_flags),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the predicted bank by one command and return the beat it must produce
	function automatic pin_result_t apply_command(input dbio_pkg::opcode_t op,
			input logic [3:0] p, input logic [31:0] dur, input logic [31:0] now,
			input logic [15:0] lev);
		pin_result_t r;
		logic [1:0]  m;
		logic        low;
		logic [31:0] elapsed;
		r = '0;
		case (op)
		dbio_pkg::OP_TICK: begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				m   = mode_word[2*i +: 2];
				low = ~lev[i];  // active low
				if (m == dbio_pkg::MODE_INPUT) begin
					case (deb_phase[i])
					dbio_pkg::PH_WAIT_SETTLE: begin
						// wrap-safe: difference taken modulo 2^32
						elapsed = now - mark_ms[i];
						if (!low) begin
							deb_phase[i] = dbio_pkg::PH_WAIT_CHANGE;
						end else if (elapsed >= {16'd0, settle_word}) begin
							deb_phase[i] = dbio_pkg::PH_WAIT_RELEASE;
							act_flags[i] = 1'b1;
						end
					end
					dbio_pkg::PH_WAIT_RELEASE: begin
						// release only counts once the flag has been read away
						if (!low && !act_flags[i])
							deb_phase[i] = dbio_pkg::PH_WAIT_CHANGE;
					end
					default: begin
						if (low) begin
							mark_ms[i]   = now;
							deb_phase[i] = dbio_pkg::PH_WAIT_SETTLE;
						end
					end
					endcase
				end else if (m == dbio_pkg::MODE_OUTPUT) begin
					// zero deadline never expires; plain unsigned compare otherwise
					if (mark_ms[i] != 32'd0 && now >= mark_ms[i]) begin
						mark_ms[i]  = 32'd0;
						drv_bits[i] = 1'b0;
					end
				end
			end
		end
		dbio_pkg::OP_DRIVE_HIGH: begin
			// acts whatever the pin mode, and shares the store with the input timer
			drv_bits[p] = 1'b1;
			mark_ms[p]  = now + dur;
		end
		dbio_pkg::OP_DRIVE_LOW: begin
			drv_bits[p] = 1'b0;
			mark_ms[p]  = 32'd0;
		end
		default: begin
			r.activated  = act_flags[p];
			act_flags[p] = 1'b0;
		end
		endcase
		r.drive_levels    = drv_bits;
		r.activated_flags = act_flags;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("%0t ns  mismatch: %s", $time, msg);
	endtask

	// one command beat; start stays high afterwards so a burst runs back to back
	task automatic send_item(input dbio_pkg::opcode_t op, input logic [3:0] p,
			input logic [31:0] dur, input logic [31:0] now, input logic [15:0] lev);
		int unsigned gap;
		if (burst_left == 0) begin
			// long bursts now and then give stretches with no idling at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start       <= 1'b1;
		opcode      <= op;
		pin         <= p;
		duration_ms <= dur;
		now_ms      <= now;
		pin_levels  <= lev;
		// busy read here is the value before the edge
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_command(op, p, dur, now, lev));
		case (op)
		dbio_pkg::OP_TICK:       n_ticks++;
		dbio_pkg::OP_DRIVE_HIGH: n_drive_high++;
		dbio_pkg::OP_DRIVE_LOW:  n_drive_low++;
		default:                 n_reads++;
		endcase
	endtask

	// register write, only once the block has gone quiet
	task automatic write_register(input logic [dbio_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == dbio_pkg::REG_PIN_MODES)
			mode_word = data;
		else if (idx == dbio_pkg::REG_SETTLE_MS)
			settle_word = data[15:0];
		n_cfg_writes++;
		burst_left = 0;
	endtask

	// settle time left at its reset value, every mode code present across the bank
	task automatic test_reset_settle();
		write_register(dbio_pkg::REG_PIN_MODES,
		               {4{MODE_UNDEF, dbio_pkg::MODE_OUTPUT, dbio_pkg::MODE_INPUT,
		                  dbio_pkg::MODE_UNUSED}});
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd1000, 16'h0000);
		send_item(dbio_pkg::OP_TICK, 4'd7, 32'hFFFF_FFFF, 32'd1049, 16'h0000);  // one ms short
		send_item(dbio_pkg::OP_TICK, 4'd15, 32'd0, 32'd1050, 16'h0000);
	endtask

	// flag returned once and then cleared; unused pins read zero
	task automatic test_read_clear();
		send_item(dbio_pkg::OP_READ_CLEAR, 4'd1, 32'd0, 32'd0, 16'hFFFF);
		send_item(dbio_pkg::OP_READ_CLEAR, 4'd1, 32'd0, 32'd0, 16'hFFFF);
		send_item(dbio_pkg::OP_READ_CLEAR, 4'd0, 32'd0, 32'd0, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd1070, 16'hFFFF);
		send_item(dbio_pkg::OP_READ_CLEAR, 4'd13, 32'd0, 32'd0, 16'hFFFF);
	endtask

	// deadlines: exact expiry, zero deadline, wrapped sum, drives on non-output pins
	task automatic test_timed_drive();
		send_item(dbio_pkg::OP_DRIVE_HIGH, 4'd2, 32'd10, 32'd2000, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd2009, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd2010, 16'hFFFF);
		// deadline wraps to 0
		send_item(dbio_pkg::OP_DRIVE_HIGH, 4'd6, 32'd16, 32'hFFFF_FFF0, 16'hFFFF);
		send_item(dbio_pkg::OP_DRIVE_HIGH, 4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(dbio_pkg::OP_DRIVE_HIGH, 4'd5, 32'd5, 32'd0, 16'hFFFF);   // input pin
		send_item(dbio_pkg::OP_DRIVE_HIGH, 4'd3, 32'd1, 32'd0, 16'hFFFF);   // undefined mode
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd100, 16'hFFFF);
		send_item(dbio_pkg::OP_DRIVE_LOW, 4'd6, 32'd0, 32'd0, 16'hFFFF);
		send_item(dbio_pkg::OP_DRIVE_LOW, 4'd3, 32'd0, 32'd0, 16'hFFFF);
	endtask

	// settle of 0 and 65535, low time spanning the 32-bit wrap, spare indexes
	task automatic test_settle_limits();
		write_register(dbio_pkg::REG_SETTLE_MS, 32'd0);
		write_register(CFG_SPARE_2, $urandom());
		write_register(CFG_SPARE_3, $urandom());
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFF0, 16'h0000);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'h0000_0005, 16'h0000);
		// upper data bits fall outside the 16-bit register
		write_register(dbio_pkg::REG_SETTLE_MS, 32'hABCD_FFFF);
		send_item(dbio_pkg::OP_READ_CLEAR, 4'd1, 32'd0, 32'd0, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'd10, 16'hFFFF);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_0000, 16'h0000);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFE, 16'h0000);
		send_item(dbio_pkg::OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF, 16'h0000);
	endtask

	// mostly well-formed traffic: time moving forward in ms steps, pins held at
	// their level across ticks, reads and timed drives, with some noise
	task automatic test_random_traffic();
		logic [31:0] clock_ms;
		logic [15:0] held;
		logic [15:0] lev;
		logic [31:0] dur;
		logic [3:0]  p;
		int unsigned dice;
		clock_ms = $urandom();
		held     = '1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: begin
				write_register(dbio_pkg::REG_PIN_MODES, {16{dbio_pkg::MODE_INPUT}});
				write_register(dbio_pkg::REG_SETTLE_MS, 32'd20);
			end
			1: begin
				write_register(dbio_pkg::REG_PIN_MODES, {16{dbio_pkg::MODE_OUTPUT}});
				write_register(dbio_pkg::REG_SETTLE_MS, 32'd0);
			end
			2: begin
				write_register(dbio_pkg::REG_PIN_MODES, $urandom());
				write_register(dbio_pkg::REG_SETTLE_MS, 32'hFFFF_FFFF);
			end
			3: begin
				write_register(dbio_pkg::REG_PIN_MODES, {16{MODE_UNDEF}});
				write_register(dbio_pkg::REG_SETTLE_MS, $urandom_range(1, 100));
			end
			4: begin
				write_register(dbio_pkg::REG_PIN_MODES, $urandom());
				write_register(dbio_pkg::REG_SETTLE_MS,
				               {16'($urandom()), 16'($urandom_range(5, 60))});
				write_register(CFG_SPARE_2, $urandom());
			end
			default: begin
				write_register(dbio_pkg::REG_PIN_MODES, 32'd0);
				write_register(dbio_pkg::REG_SETTLE_MS, {16'd0, dbio_pkg::SETTLE_RESET});
			end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				dice = $urandom_range(0, 99);
				p    = 4'($urandom_range(0, 15));
				if (dice < 55) begin
					// occasional jump anywhere on the time line
					if ($urandom_range(0, 19) == 0)
						clock_ms = $urandom();
					else
						clock_ms = clock_ms + $urandom_range(1, 40);
					if ($urandom_range(0, 2) == 0)
						held[p] = ~held[p];
					lev = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : held;
					send_item(dbio_pkg::OP_TICK, p, $urandom(), clock_ms, lev);
				end else if (dice < 70) begin
					send_item(dbio_pkg::OP_READ_CLEAR, p, $urandom(), $urandom(),
					          16'($urandom()));
				end else if (dice < 85) begin
					dur = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 200);
					send_item(dbio_pkg::OP_DRIVE_HIGH, p, dur, clock_ms, held);
				end else if (dice < 95) begin
					send_item(dbio_pkg::OP_DRIVE_LOW, p, $urandom(), clock_ms, held);
				end else begin
					send_item(dbio_pkg::opcode_t'($urandom_range(0, 3)), p, $urandom(),
					          $urandom(), 16'($urandom()));
				end
			end
		end
	endtask

	// checker: the result beat is valid only in the done cycle
	always @(posedge clk) begin : result_check
		pin_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding: %h %b %h",
				                          drive_levels, activated, activated_flags));
			end else begin
				want = pending_results.pop_front();
				if (want.activated)
					n_flags_read++;
				if (drive_levels !== want.drive_levels)
					report_mismatch($sformatf("drive_levels got %h want %h",
					                          drive_levels, want.drive_levels));
				if (activated !== want.activated)
					report_mismatch($sformatf("activated got %b want %b",
					                          activated, want.activated));
				if (activated_flags !== want.activated_flags)
					report_mismatch($sformatf("activated_flags got %h want %h",
					                          activated_flags, want.activated_flags));
			end
		end
	end

	// watchdog: any accepted beat on any channel counts as progress
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t ns  no progress for %0d cycles", $time, STALL_LIMIT);
		$display("tb_debounced_input_and_timed_output_pins: errors");
		$finish;
	end

	initial begin : stimulus
		arst_n      <= 1'b0;
		start       <= 1'b0;
		opcode      <= dbio_pkg::OP_TICK;
		pin         <= '0;
		duration_ms <= '0;
		now_ms      <= '0;
		pin_levels  <= '1;
		cfg_valid   <= 1'b0;
		cfg_index   <= dbio_pkg::REG_PIN_MODES;
		cfg_data    <= '0;

		// predicted state after reset
		mode_word   = '0;
		settle_word = dbio_pkg::SETTLE_RESET;
		act_flags   = '0;
		drv_bits    = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			deb_phase[i] = dbio_pkg::PH_WAIT_CHANGE;
			mark_ms[i]   = '0;
		end
		error_count  = 0;
		burst_left   = 0;
		n_ticks      = 0;
		n_drive_high = 0;
		n_drive_low  = 0;
		n_reads      = 0;
		n_flags_read = 0;
		n_cfg_writes = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settle();
		test_read_clear();
		test_timed_drive();
		test_settle_limits();
		test_random_traffic();

		// drain: wait for every owed beat, then let the clock run on before finishing
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d ticks, %0d timed drives, %0d drive-lows, %0d read-clears (%0d set)",
		         n_ticks, n_drive_high, n_drive_low, n_reads, n_flags_read);
		$display("over %0d register writes, settle 0 to 65535, all four mode codes per pin",
		         n_cfg_writes);
		if (error_count == 0)
			$display("tb_debounced_input_and_timed_output_pins: clean");
		else
			$display("tb_debounced_input_and_timed_output_pins: errors");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/dbio_pkg.sv
hdl/dbio_alu.sv
hdl/dbio_mark_mem.sv
hdl/debounced_input_and_timed_output_pins.sv
tb/tb_debounced_input_and_timed_output_pins.sv
